// ===== src/sssc_pkg.sv =====
// Package for the seven-segment scan controller.
// Holds request codes, justify codes, the sequencer state type and the glyph table.
// No dependencies.
package sssc_pkg;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_NUMBER = 3'd1,
        REQ_STRING = 3'd2,
        REQ_FILL   = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    localparam logic [1:0] JUST_CENTRE = 2'd1;
    localparam logic [1:0] JUST_RIGHT  = 2'd2;

    localparam int DECIMAL_DIGITS = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CLEAR,
        ST_PLACE
    } state_t;

    function automatic logic [7:0] glyph(input logic [7:0] code);
        logic [7:0] g;
        g = 8'h00;
        case (code)
            8'd33: g = 8'h86; 8'd34: g = 8'h22; 8'd35: g = 8'h7E; 8'd36: g = 8'h6D;
            8'd37: g = 8'hD2; 8'd38: g = 8'h46; 8'd39: g = 8'h20; 8'd40: g = 8'h29;
            8'd41: g = 8'h0B; 8'd42: g = 8'h21; 8'd43: g = 8'h70; 8'd44: g = 8'h10;
            8'd45: g = 8'h40; 8'd46: g = 8'h80; 8'd47: g = 8'h52;
            8'd48: g = 8'h3F; 8'd49: g = 8'h06; 8'd50: g = 8'h5B; 8'd51: g = 8'h4F;
            8'd52: g = 8'h66; 8'd53: g = 8'h6D; 8'd54: g = 8'h7D; 8'd55: g = 8'h07;
            8'd56: g = 8'h7F; 8'd57: g = 8'h6F; 8'd58: g = 8'h09; 8'd59: g = 8'h0D;
            8'd60: g = 8'h61; 8'd61: g = 8'h48; 8'd62: g = 8'h43; 8'd63: g = 8'hD3;
            8'd64: g = 8'h5F; 8'd65: g = 8'h77; 8'd66: g = 8'h7C; 8'd67: g = 8'h39;
            8'd68: g = 8'h5E; 8'd69: g = 8'h79; 8'd70: g = 8'h71; 8'd71: g = 8'h3D;
            8'd72: g = 8'h76; 8'd73: g = 8'h30; 8'd74: g = 8'h1E; 8'd75: g = 8'h75;
            8'd76: g = 8'h38; 8'd77: g = 8'h15; 8'd78: g = 8'h37; 8'd79: g = 8'h3F;
            8'd80: g = 8'h73; 8'd81: g = 8'h6B; 8'd82: g = 8'h33; 8'd83: g = 8'h6D;
            8'd84: g = 8'h78; 8'd85: g = 8'h3E; 8'd86: g = 8'h3E; 8'd87: g = 8'h2A;
            8'd88: g = 8'h76; 8'd89: g = 8'h6E; 8'd90: g = 8'h5B; 8'd91: g = 8'h39;
            8'd92: g = 8'h64; 8'd93: g = 8'h0F; 8'd94: g = 8'h23; 8'd95: g = 8'h08;
            8'd96: g = 8'h02; 8'd97: g = 8'h5F; 8'd98: g = 8'h7C; 8'd99: g = 8'h58;
            8'd100: g = 8'h5E; 8'd101: g = 8'h7B; 8'd102: g = 8'h71; 8'd103: g = 8'h6F;
            8'd104: g = 8'h74; 8'd105: g = 8'h10; 8'd106: g = 8'h0C; 8'd107: g = 8'h75;
            8'd108: g = 8'h30; 8'd109: g = 8'h14; 8'd110: g = 8'h54; 8'd111: g = 8'h5C;
            8'd112: g = 8'h73; 8'd113: g = 8'h67; 8'd114: g = 8'h50; 8'd115: g = 8'h6D;
            8'd116: g = 8'h78; 8'd117: g = 8'h1C; 8'd118: g = 8'h1C; 8'd119: g = 8'h14;
            8'd120: g = 8'h76; 8'd121: g = 8'h6E; 8'd122: g = 8'h5B; 8'd123: g = 8'h46;
            8'd124: g = 8'h30; 8'd125: g = 8'h70; 8'd126: g = 8'h01;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        return glyph(8'd48 + {4'd0, d});
    endfunction

endpackage

// ===== src/seven_segment_scan_controller_unit.sv =====
// Multiplexed seven-segment display controller.
// A ticked scan over a digit store filled by number, string, fill and clear words.
// Depends on sssc_pkg.
//
// Usage: request words enter on s_axis (tdata, tuser holds the request kind).
// Only a scan tick gives an output word on m_axis; it carries the digit's
// segment levels, its index and whether the digit is lit.
// A tick's output word is registered at the accepting edge. A string character
// that does not commit leaves the block idle. Fill and clear keep the block busy
// through a clearing pass over the live digits, a final string character through
// that pass and the placing of its characters. A number write runs one shared
// divide-by-ten step per cycle (one to ten steps), then the clearing pass and the
// placing of its digits. s_axis_tready is low while a request is at work or an
// output word waits, so a stalled receiver holds the output word and blocks new
// requests. Reset blanks the store, zeroes the scan position and the held
// segments, and sets the digit count to 4 and the polarity to zero; no clearing
// pass. Configuration writes go through cfg_we, cfg_index, cfg_wdata; the user
// must make them only while idle, as the block itself does not enforce this.
module seven_segment_scan_controller_unit #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // number_value[31:0], char_code[39:32], justify[41:40], zero fill [47:42]
    input  logic [47:0] s_axis_tdata,
    // req_type
    input  logic [2:0]  s_axis_tuser,
    // last_char
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // segments[7:0], digit_index[10:8], zero fill [15:11]
    output logic [15:0] m_axis_tdata,
    // digit_on
    output logic        m_axis_tuser
);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int LW = (CW > 4) ? CW : 4;

    sssc_pkg::state_t state_reg, state_next;

    logic [3:0]  count_reg;
    logic        cathode_reg;
    logic [7:0]  store_reg [MAX_DIGITS];
    logic [7:0]  stage_reg [MAX_DIGITS];
    logic [CW-1:0] slen_reg;
    logic [IW-1:0] scan_reg;
    logic [7:0]  hold_reg;
    logic [3:0]  dec_reg [sssc_pkg::DECIMAL_DIGITS];
    logic [3:0]  ndig_reg;
    logic [31:0] val_reg;
    logic [1:0]  just_reg;
    logic        src_num_reg;
    logic [7:0]  fill_reg;
    logic [LW-1:0] pos_reg;
    logic [LW-1:0] m_reg;
    logic [LW-1:0] off_reg;
    logic        out_valid_reg;
    logic [7:0]  out_seg_reg;
    logic [2:0]  out_idx_reg;
    logic        out_on_reg;

    logic [LW-1:0] live;
    logic        accept;
    logic [2:0]  req;
    logic [31:0] quot;
    logic [3:0]  rem;
    logic [35:0] prod;
    logic [LW-1:0] m_now;
    logic [LW-1:0] rel;
    logic [3:0]  dsel;
    logic [IW-1:0] pos_idx;
    logic [IW-1:0] tick_idx;

    assign live = (LW'(count_reg) > LW'(MAX_DIGITS)) ? LW'(MAX_DIGITS) : LW'(count_reg);
    assign s_axis_tready = (state_reg == sssc_pkg::ST_IDLE) && !out_valid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign req = s_axis_tuser;

    // Divide by ten through a reciprocal multiply; the remainder comes from a multiply back and subtract.
    always_comb
    begin
        logic [63:0] full;
        full = {32'd0, val_reg} * 64'hCCCCCCCD;
        quot = 32'(full >> 35);
        prod = {4'd0, quot} * 36'd10;
        rem  = 4'(36'({4'd0, val_reg}) - prod);
    end

    assign m_now = (LW'(slen_reg) < live) ? LW'(slen_reg) : live;
    assign rel = pos_reg - off_reg;
    assign dsel = 4'(ndig_reg - 4'd1 - 4'(rel));
    assign pos_idx = IW'(pos_reg);
    assign tick_idx = (LW'(scan_reg) >= live) ? '0 : scan_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sssc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req == sssc_pkg::REQ_NUMBER)
                        state_next = sssc_pkg::ST_CONV;
                    else if ((req == sssc_pkg::REQ_STRING && s_axis_tlast)
                             || req == sssc_pkg::REQ_FILL || req == sssc_pkg::REQ_CLEAR)
                        state_next = sssc_pkg::ST_CLEAR;
                end
            end
            sssc_pkg::ST_CONV:
            begin
                if (quot == 32'd0 || ndig_reg == 4'(sssc_pkg::DECIMAL_DIGITS - 1))
                    state_next = sssc_pkg::ST_CLEAR;
            end
            sssc_pkg::ST_CLEAR:
            begin
                if (pos_reg >= live)
                    state_next = (m_reg != '0) ? sssc_pkg::ST_PLACE : sssc_pkg::ST_IDLE;
            end
            sssc_pkg::ST_PLACE:
            begin
                if (rel + LW'(1) >= m_reg)
                    state_next = sssc_pkg::ST_IDLE;
            end
            default: state_next = sssc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sssc_pkg::ST_IDLE;
            count_reg     <= 4'd4;
            cathode_reg   <= 1'b0;
            slen_reg      <= '0;
            scan_reg      <= '0;
            hold_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++)
                store_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    count_reg <= cfg_wdata;
                else
                    cathode_reg <= cfg_wdata[0];
            end
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                sssc_pkg::ST_IDLE:
                begin
                    pos_reg <= '0;
                    ndig_reg <= 4'd0;
                    val_reg <= s_axis_tdata[31:0];
                    just_reg <= s_axis_tdata[41:40];
                    src_num_reg <= (req == sssc_pkg::REQ_NUMBER);
                    fill_reg <= (req == sssc_pkg::REQ_FILL) ?
                                sssc_pkg::glyph(s_axis_tdata[7:0]) : 8'd0;
                    if (accept && req == sssc_pkg::REQ_TICK && live != '0)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg <= 3'(tick_idx);
                        if (store_reg[tick_idx] != 8'd0)
                        begin
                            hold_reg <= store_reg[tick_idx] ^ {8{cathode_reg}};
                            out_seg_reg <= store_reg[tick_idx] ^ {8{cathode_reg}};
                            out_on_reg <= 1'b1;
                        end
                        else
                        begin
                            out_seg_reg <= hold_reg;
                            out_on_reg <= 1'b0;
                        end
                        scan_reg <= (LW'(tick_idx) + LW'(1) >= live) ? '0 :
                                    IW'(LW'(tick_idx) + LW'(1));
                    end
                    if (accept && req == sssc_pkg::REQ_STRING)
                    begin
                        if (LW'(slen_reg) < LW'(MAX_DIGITS))
                        begin
                            stage_reg[IW'(slen_reg)] <= sssc_pkg::glyph(s_axis_tdata[39:32]);
                            if (s_axis_tlast)
                                slen_reg <= '0;
                            else
                                slen_reg <= slen_reg + CW'(1);
                            begin
                                logic [LW-1:0] l, mm;
                                l = LW'(slen_reg) + LW'(1);
                                mm = (l < live) ? l : live;
                                m_reg <= mm;
                                off_reg <= (s_axis_tdata[41:40] == sssc_pkg::JUST_CENTRE) ?
                                           ((live - mm) >> 1) :
                                           (s_axis_tdata[41:40] == sssc_pkg::JUST_RIGHT) ?
                                           (live - mm) : '0;
                            end
                        end
                        else
                        begin
                            if (s_axis_tlast)
                                slen_reg <= '0;
                            m_reg <= m_now;
                            off_reg <= (s_axis_tdata[41:40] == sssc_pkg::JUST_CENTRE) ?
                                       ((live - m_now) >> 1) :
                                       (s_axis_tdata[41:40] == sssc_pkg::JUST_RIGHT) ?
                                       (live - m_now) : '0;
                        end
                    end
                    else
                    begin
                        m_reg <= '0;
                        off_reg <= '0;
                    end
                end
                sssc_pkg::ST_CONV:
                begin
                    dec_reg[ndig_reg] <= rem;
                    ndig_reg <= ndig_reg + 4'd1;
                    val_reg <= quot;
                    begin
                        logic [LW-1:0] l, mm;
                        l = LW'(ndig_reg) + LW'(1);
                        mm = (l < live) ? l : live;
                        m_reg <= mm;
                        off_reg <= (just_reg == sssc_pkg::JUST_CENTRE) ? ((live - mm) >> 1) :
                                   (just_reg == sssc_pkg::JUST_RIGHT) ? (live - mm) : '0;
                    end
                end
                sssc_pkg::ST_CLEAR:
                begin
                    if (pos_reg < live)
                    begin
                        store_reg[pos_idx] <= fill_reg;
                        pos_reg <= pos_reg + LW'(1);
                    end
                    else
                        pos_reg <= off_reg;
                end
                sssc_pkg::ST_PLACE:
                begin
                    store_reg[pos_idx] <= src_num_reg ?
                        sssc_pkg::digit_glyph(dec_reg[dsel]) : stage_reg[IW'(rel)];
                    pos_reg <= pos_reg + LW'(1);
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_idx_reg, out_seg_reg};
    assign m_axis_tuser  = out_on_reg;

endmodule
